FILE: sv/spc_pkg.sv
// shared types and constants for the sphere pair contact block
`timescale 1ns / 1ps

package spc_pkg;

    localparam int COORD_BITS_DEF  = 24;
    localparam int NORMAL_BITS_DEF = 16;
    localparam int TOL_BITS        = 12;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 12'd1;

    typedef enum logic [1:0] {
        REG_COINCIDE_TOLERANCE = 2'd0
    } reg_index_t;

endpackage

FILE: sv/spc_if.sv
// valid/ready channel interfaces for sphere pairs and contact results
`timescale 1ns / 1ps

interface spc_pair_if #(
    parameter int COORD_BITS = spc_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_BITS-1:0]  a_center_x;
    logic signed [COORD_BITS-1:0]  a_center_y;
    logic signed [COORD_BITS-1:0]  a_center_z;
    logic        [COORD_BITS-2:0]  a_radius;
    logic signed [COORD_BITS-1:0]  b_center_x;
    logic signed [COORD_BITS-1:0]  b_center_y;
    logic signed [COORD_BITS-1:0]  b_center_z;
    logic        [COORD_BITS-2:0]  b_radius;

    modport source (output valid, a_center_x, a_center_y, a_center_z, a_radius,
                    b_center_x, b_center_y, b_center_z, b_radius, input ready);
    modport sink (input valid, a_center_x, a_center_y, a_center_z, a_radius,
                  b_center_x, b_center_y, b_center_z, b_radius, output ready);
endinterface

interface spc_contact_if #(
    parameter int COORD_BITS  = spc_pkg::COORD_BITS_DEF,
    parameter int NORMAL_BITS = spc_pkg::NORMAL_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          overlapping;
    logic signed [NORMAL_BITS-1:0] normal_x;
    logic signed [NORMAL_BITS-1:0] normal_y;
    logic signed [NORMAL_BITS-1:0] normal_z;
    logic        [COORD_BITS-1:0]  penetration;

    modport source (output valid, overlapping, normal_x, normal_y, normal_z,
                    penetration, input ready);
    modport sink (input valid, overlapping, normal_x, normal_y, normal_z,
                  penetration, output ready);
endinterface

FILE: sv/spc_sqrt_stage.sv
// one restoring square root step: settles one result bit per stage
`timescale 1ns / 1ps

module spc_sqrt_stage #(
    parameter int RW  = 26,
    parameter int RMW = 28,
    parameter int BIT = 0
) (
    input  logic [RMW-1:0] rem_in,
    input  logic [RW-1:0]  root_in,
    output logic [RMW-1:0] rem_out,
    output logic [RW-1:0]  root_out
);
    // non-restoring-free form: trial = (root << (BIT+1)) + (1 << 2*BIT)
    logic [RMW+RW+1:0] trial;
    logic [RMW+RW+1:0] rem_ext;

    always_comb
    begin
        trial   = ((RMW+RW+2)'(root_in) << (BIT + 1)) + ((RMW+RW+2)'(1) << (2 * BIT));
        rem_ext = (RMW+RW+2)'(rem_in);
        if (trial <= rem_ext)
        begin
            rem_out  = RMW'(rem_ext - trial);
            root_out = root_in | (RW'(1) << BIT);
        end
        else
        begin
            rem_out  = rem_in;
            root_out = root_in;
        end
    end
endmodule

FILE: sv/spc_div_stage.sv
// one restoring division step: one quotient bit per stage
`timescale 1ns / 1ps

module spc_div_stage #(
    parameter int NW = 40,
    parameter int DW = 26,
    parameter int QW = 16,
    parameter int BIT = 0
) (
    input  logic [NW-1:0] rem_in,
    input  logic [DW-1:0] den,
    input  logic [QW-1:0] q_in,
    output logic [NW-1:0] rem_out,
    output logic [QW-1:0] q_out
);
    logic [NW+QW:0] shifted;

    always_comb
    begin
        shifted = (NW+QW+1)'(den) << BIT;
        if (shifted <= (NW+QW+1)'(rem_in))
        begin
            rem_out = NW'((NW+QW+1)'(rem_in) - shifted);
            q_out   = q_in | (QW'(1) << BIT);
        end
        else
        begin
            rem_out = rem_in;
            q_out   = q_in;
        end
    end
endmodule

FILE: sv/spc_apb_regs.sv
// apb register file holding the coincidence tolerance
`timescale 1ns / 1ps

module spc_apb_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [1:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output logic [spc_pkg::TOL_BITS-1:0] tolerance
);
    logic [spc_pkg::TOL_BITS-1:0] tol_reg;
    logic                         sel_tol;

    assign sel_tol = (paddr == 2'(spc_pkg::REG_COINCIDE_TOLERANCE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= spc_pkg::TOL_RESET;
        else if (psel && penable && pwrite && sel_tol)
            tol_reg <= pwdata[spc_pkg::TOL_BITS-1:0];
    end

    assign pready    = 1'b1;
    assign prdata    = sel_tol ? 32'(tol_reg) : 32'd0;
    assign tolerance = tol_reg;
endmodule

FILE: sv/spc_pipe.sv
// contact datapath: deltas, squares, square root and division pipeline
`timescale 1ns / 1ps

module spc_pipe #(
    parameter int COORD_BITS  = spc_pkg::COORD_BITS_DEF,
    parameter int NORMAL_BITS = spc_pkg::NORMAL_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [spc_pkg::TOL_BITS-1:0] tolerance,
    spc_pair_if.sink                     in_ch,
    spc_contact_if.source                out_ch
);
    localparam int DW  = COORD_BITS + 1;          // delta magnitude width
    localparam int SQW = 2 * DW + 2;              // squared distance width
    localparam int RW  = (SQW + 1) / 2;           // root width
    localparam int RMW = SQW + 1;                 // remainder width
    localparam int NF  = NORMAL_BITS - 2;
    localparam int QW  = NF + 1;
    localparam int NW  = DW + NF;
    localparam int SW  = COORD_BITS;              // radius sum width
    // stages: 1 delta, 2 square, 3 sum/compare, sqrt RW stages, 1 tol, div QW, out
    localparam int S_SQ   = 3;
    localparam int S_DIV  = S_SQ + RW + 1;
    localparam int DEPTH  = S_DIV + QW + 1;
    localparam int LAST   = S_DIV + QW;

    logic advance;
    assign advance = !out_ch.valid || out_ch.ready;
    assign in_ch.ready = advance;

    logic [DEPTH-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[DEPTH-2:0], in_ch.valid};
    end

    // stage 1: deltas and radius sum
    logic [DW-1:0] mx_reg [1:2], my_reg [1:2], mz_reg [1:2];
    logic [2:0]    sg_reg [1:LAST];
    logic [SW-1:0] rs_reg [1:S_DIV-1];
    logic signed [DW-1:0] dx, dy, dz;
    always_comb
    begin
        dx = DW'(in_ch.b_center_x) - DW'(in_ch.a_center_x);
        dy = DW'(in_ch.b_center_y) - DW'(in_ch.a_center_y);
        dz = DW'(in_ch.b_center_z) - DW'(in_ch.a_center_z);
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mx_reg[1] <= dx[DW-1] ? DW'(-dx) : DW'(dx);
            my_reg[1] <= dy[DW-1] ? DW'(-dy) : DW'(dy);
            mz_reg[1] <= dz[DW-1] ? DW'(-dz) : DW'(dz);
            sg_reg[1] <= {dx[DW-1], dy[DW-1], dz[DW-1]};
            rs_reg[1] <= SW'(in_ch.a_radius) + SW'(in_ch.b_radius);
            mx_reg[2] <= mx_reg[1];
            my_reg[2] <= my_reg[1];
            mz_reg[2] <= mz_reg[1];
            for (int s = 2; s <= LAST; s++)
                sg_reg[s] <= sg_reg[s-1];
            for (int s = 2; s < S_DIV; s++)
                rs_reg[s] <= rs_reg[s-1];
        end
    end

    // stage 2: squares; stage 3: sum and overlap compare
    logic [2*DW-1:0] px_reg, py_reg, pz_reg, rq_reg;
    logic [SQW-1:0]  dsq_reg;
    logic            ov_reg [3:LAST];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            px_reg  <= (2*DW)'(mx_reg[1]) * (2*DW)'(mx_reg[1]);
            py_reg  <= (2*DW)'(my_reg[1]) * (2*DW)'(my_reg[1]);
            pz_reg  <= (2*DW)'(mz_reg[1]) * (2*DW)'(mz_reg[1]);
            rq_reg  <= (2*DW)'(rs_reg[1]) * (2*DW)'(rs_reg[1]);
            dsq_reg <= SQW'(px_reg) + SQW'(py_reg) + SQW'(pz_reg);
            ov_reg[3] <= SQW'(rq_reg) > (SQW'(px_reg) + SQW'(py_reg) + SQW'(pz_reg));
            for (int s = 4; s <= LAST; s++)
                ov_reg[s] <= ov_reg[s-1];
        end
    end

    // delta magnitude carried alongside the root stages
    logic [DW-1:0] cx_reg [3:S_DIV], cy_reg [3:S_DIV], cz_reg [3:S_DIV];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cx_reg[3] <= mx_reg[2];
            cy_reg[3] <= my_reg[2];
            cz_reg[3] <= mz_reg[2];
            for (int s = 4; s <= S_DIV; s++)
            begin
                cx_reg[s] <= cx_reg[s-1];
                cy_reg[s] <= cy_reg[s-1];
                cz_reg[s] <= cz_reg[s-1];
            end
        end
    end

    // square root: one bit per stage, stages S_SQ+1 .. S_SQ+RW
    logic [RMW-1:0] rem_reg  [S_SQ:S_SQ+RW];
    logic [RW-1:0]  root_reg [S_SQ:S_SQ+RW];
    always_comb
    begin
        rem_reg[S_SQ]  = RMW'(dsq_reg);
        root_reg[S_SQ] = '0;
    end
    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        logic [RMW-1:0] rem_n;
        logic [RW-1:0]  root_n;
        spc_sqrt_stage #(.RW(RW), .RMW(RMW), .BIT(RW - 1 - k)) u_stage (
            .rem_in  (rem_reg[S_SQ+k]),
            .root_in (root_reg[S_SQ+k]),
            .rem_out (rem_n),
            .root_out(root_n)
        );
        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[S_SQ+k+1]  <= rem_n;
                root_reg[S_SQ+k+1] <= root_n;
            end
        end
    end

    // tolerance stage and penetration
    logic [RW-1:0]  dist_reg [S_DIV:LAST-1];
    logic           co_reg   [S_DIV:LAST];
    logic [SW-1:0]  pen_reg  [S_DIV:LAST];
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dist_reg[S_DIV] <= root_reg[S_SQ+RW];
            co_reg[S_DIV]   <= (root_reg[S_SQ+RW] <= RW'(tolerance));
            pen_reg[S_DIV]  <= SW'(rs_reg[S_DIV-1] - SW'(root_reg[S_SQ+RW]));
            for (int s = S_DIV + 1; s < LAST; s++)
                dist_reg[s] <= dist_reg[s-1];
            for (int s = S_DIV + 1; s <= LAST; s++)
            begin
                co_reg[s]   <= co_reg[s-1];
                pen_reg[s]  <= pen_reg[s-1];
            end
        end
    end

    // division: three lanes, one quotient bit per stage
    logic [NW-1:0] drem_reg [3][S_DIV:S_DIV+QW];
    logic [QW-1:0] q_reg    [3][S_DIV:S_DIV+QW];
    always_comb
    begin
        drem_reg[0][S_DIV] = NW'(cx_reg[S_DIV]) << NF;
        drem_reg[1][S_DIV] = NW'(cy_reg[S_DIV]) << NF;
        drem_reg[2][S_DIV] = NW'(cz_reg[S_DIV]) << NF;
        q_reg[0][S_DIV]    = '0;
        q_reg[1][S_DIV]    = '0;
        q_reg[2][S_DIV]    = '0;
    end
    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        for (genvar k = 0; k < QW; k++)
        begin : g_div
            logic [NW-1:0] rn;
            logic [QW-1:0] qn;
            spc_div_stage #(.NW(NW), .DW(RW), .QW(QW), .BIT(QW - 1 - k)) u_stage (
                .rem_in (drem_reg[l][S_DIV+k]),
                .den    (dist_reg[S_DIV+k]),
                .q_in   (q_reg[l][S_DIV+k]),
                .rem_out(rn),
                .q_out  (qn)
            );
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    drem_reg[l][S_DIV+k+1] <= rn;
                    q_reg[l][S_DIV+k+1]    <= qn;
                end
            end
        end
    end

    // output stage
    logic signed [NORMAL_BITS-1:0] nrm [3];
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            nrm[l] = NORMAL_BITS'(q_reg[l][LAST]);
            if (sg_reg[LAST][2-l])
                nrm[l] = -nrm[l];
        end
    end

    logic                          ovo_reg;
    logic signed [NORMAL_BITS-1:0] nx_reg, ny_reg, nz_reg;
    logic [COORD_BITS-1:0]         po_reg;
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ovo_reg <= ov_reg[LAST];
            if (!ov_reg[LAST])
            begin
                nx_reg <= '0;
                ny_reg <= '0;
                nz_reg <= '0;
                po_reg <= '0;
            end
            else if (co_reg[LAST])
            begin
                nx_reg <= '0;
                ny_reg <= NORMAL_BITS'(1) << NF;
                nz_reg <= '0;
                po_reg <= pen_reg[LAST];
            end
            else
            begin
                nx_reg <= nrm[0];
                ny_reg <= nrm[1];
                nz_reg <= nrm[2];
                po_reg <= pen_reg[LAST];
            end
        end
    end

    assign out_ch.valid       = vld_reg[DEPTH-1];
    assign out_ch.overlapping = ovo_reg;
    assign out_ch.normal_x    = nx_reg;
    assign out_ch.normal_y    = ny_reg;
    assign out_ch.normal_z    = nz_reg;
    assign out_ch.penetration = po_reg;
endmodule

FILE: sv/sphere_pair_contact_core.sv
// top level of the sphere pair contact block
`timescale 1ns / 1ps

// Takes one sphere pair per cycle unless the result sink stalls, and returns one
// contact result per pair, in order. The pipeline has a delta stage, a square
// stage, a sum and compare stage, one stage per square root bit (COORD_BITS+2
// bits), a tolerance stage, one stage per normal quotient bit (NORMAL_BITS-1
// bits) and an output register; 46 stages at the default widths. The whole
// pipeline holds when the result sink stalls. The tolerance register sits at
// byte address 0.
module sphere_pair_contact_core #(
    parameter int COORD_BITS  = spc_pkg::COORD_BITS_DEF,
    parameter int NORMAL_BITS = spc_pkg::NORMAL_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    spc_pair_if.sink    pair,
    spc_contact_if.source contact
);
    logic [spc_pkg::TOL_BITS-1:0] tolerance;

    spc_apb_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .tolerance(tolerance)
    );

    spc_pipe #(.COORD_BITS(COORD_BITS), .NORMAL_BITS(NORMAL_BITS)) u_pipe (
        .clk      (clk),
        .rst_n    (rst_n),
        .tolerance(tolerance),
        .in_ch    (pair),
        .out_ch   (contact)
    );

    a_no_overlap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        contact.valid && !contact.overlapping |->
            contact.penetration == '0 && contact.normal_y == '0)
        else $error("non-overlap result carries data");

    a_ready_follows_sink: assert property (@(posedge clk) disable iff (!rst_n)
        contact.valid && !contact.ready |-> !pair.ready)
        else $error("input taken while output stalled");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $past(contact.valid && !contact.ready) |-> $stable(contact.penetration))
        else $error("result changed under stall");
endmodule
